// ===== src/tppg_pkg.sv =====
// Package with the shared types, constants and trig table functions of the pass point generator.
`timescale 1ns / 1ps
`default_nettype none
package tppg_pkg;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FORWARD  = 8'd1;

  // Kind of an input word, carried on in_tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MUL_LAST  = 6'd32;
  localparam logic [CNT_W-1:0] ROOT_LAST = 6'd32;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd62;

  localparam logic [63:0] Q30_ONE  = 64'd1073741824;
  localparam logic [63:0] Q30_HALF = 64'd536870912;
  localparam logic [63:0] PI_Q30   = 64'd3373259426;

  localparam logic [63:0] SIN_K [7] = '{64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20,
                                        64'd6};
  localparam logic [63:0] COS_K [6] = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_LD,
    ST_ROOT,
    ST_DIV_LD,
    ST_DIV,
    ST_DIR,
    ST_MUL,
    ST_COMBINE,
    ST_OUT
  } state_t;

  // Control of a serial arithmetic unit: load operands, or advance one bit.
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

  function automatic logic [63:0] tppg_angle(input logic [63:0] f);
    logic [63:0] fc;
    logic [63:0] g;
    fc = (f > Q30_ONE) ? Q30_ONE : f;
    g  = (fc > Q30_ONE / 2) ? Q30_ONE - fc : fc;
    return (g * PI_Q30 + Q30_HALF) >> 30;
  endfunction

  function automatic logic tppg_cos_fold(input logic [63:0] f);
    logic [63:0] fc;
    fc = (f > Q30_ONE) ? Q30_ONE : f;
    return fc > Q30_ONE / 2;
  endfunction

  function automatic logic [30:0] tppg_sin_mag(input logic [63:0] f);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] s;
    x  = tppg_angle(f);
    x2 = (x * x + Q30_HALF) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 7; k++) begin
      p = ((x2 * t) >> 30) / SIN_K[k];
      t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    end
    s = (x * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return s[30:0];
  endfunction

  function automatic logic [30:0] tppg_cos_mag(input logic [63:0] f);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] c;
    x  = tppg_angle(f);
    x2 = (x * x + Q30_HALF) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      p = ((x2 * t) >> 30) / COS_K[k];
      t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    end
    p = ((x2 * t) >> 30) / 2;
    c = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    return c[30:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/trochoidal_pass_point_generator.sv =====
// Top level of the trochoidal pass point generator.
`timescale 1ns / 1ps
`default_nettype none
// A load word (in_tuser = 0) gives a straight segment in Q16.16 millimetres; the block works
// out its length with a bit-serial square root and its unit direction with two serial
// divisions, and gives no result word. Each next word (in_tuser = 1) returns one feed point of
// the trochoidal pass: half circles of circle_radius whose centres step along the segment by
// step_forward, alternating between the upper and lower half, ARC_SEGMENTS+1 points each.
// A load works through the two squares, the square root and the divisions in turn, all
// done by the one-bit-per-cycle shift-add and restoring units. A point is worked out by the
// serial multipliers and then waits for out_tready when the previous point has not been
// taken. A next word with no active pass is taken and gives nothing. Input words are taken
// one at a time, while a finished point may still wait in the output register.
// Configuration writes are taken in every cycle and must only come while the block is idle.
module trochoidal_pass_point_generator #(
  parameter int ARC_SEGMENTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input channel.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata, from bit 0: start_x, start_y, level_z, end_x, end_y.
  input  wire logic [159:0] in_tdata,
  // tuser: kind (0 load segment, 1 next point).
  input  wire logic         in_tuser,
  // Result channel.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata, from bit 0: point_x, point_y, point_z.
  output logic      [95:0]  out_tdata,
  // tuser: end_of_arc.
  output logic              out_tuser,
  // tlast: end_of_pass.
  output logic              out_tlast,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [tppg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int IDX_W = $clog2(ARC_SEGMENTS + 1);

  // Cosine and sine magnitudes of each point of a half circle, built at elaboration.
  logic [30:0] cos_tab  [ARC_SEGMENTS+1];
  logic [30:0] sin_tab  [ARC_SEGMENTS+1];
  logic        fold_tab [ARC_SEGMENTS+1];

  for (genvar gi = 0; gi <= ARC_SEGMENTS; gi++) begin : g_tab
    localparam logic [63:0] F_RAW =
      (64'(gi) * tppg_pkg::Q30_ONE + 64'(ARC_SEGMENTS / 2)) / 64'(ARC_SEGMENTS);
    assign cos_tab[gi]  = tppg_pkg::tppg_cos_mag(F_RAW);
    assign sin_tab[gi]  = tppg_pkg::tppg_sin_mag(F_RAW);
    assign fold_tab[gi] = tppg_pkg::tppg_cos_fold(F_RAW);
  end

  tppg_pkg::state_t state_r, state_nxt;
  logic [tppg_pkg::CNT_W-1:0] cnt_r;

  logic [30:0] radius_r;
  logic [30:0] step_r;

  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_y_r;
  logic        [31:0] height_z_r;
  logic [30:0] dir_x_mag_r;
  logic [30:0] dir_y_mag_r;
  logic        dir_x_neg_r;
  logic        dir_y_neg_r;
  logic [32:0] seg_len_r;
  logic [32:0] trav_r;
  logic        upper_r;
  logic [IDX_W-1:0] idx_r;
  logic        active_r;

  logic [32:0] ux_r;
  logic [32:0] uy_r;
  logic        cneg_r;
  logic        sneg_r;

  logic [65:0] rad_r;
  logic [33:0] rem_r;
  logic [32:0] root_r;

  logic signed [34:0] cx_r;
  logic signed [34:0] cy_r;
  logic [31:0] rx_mag_r;
  logic [31:0] ry_mag_r;

  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_arc_r;
  logic        out_last_r;

  logic accept;
  logic out_free;
  tppg_pkg::ctl_t mul_ctl;
  tppg_pkg::ctl_t div_ctl;

  // Segment difference of the word at the input.
  logic signed [32:0] dx_in;
  logic signed [32:0] dy_in;
  logic [32:0] ux_in;
  logic [32:0] uy_in;

  assign dx_in = $signed({in_tdata[127], in_tdata[127:96]})
               - $signed({in_tdata[31], in_tdata[31:0]});
  assign dy_in = $signed({in_tdata[159], in_tdata[159:128]})
               - $signed({in_tdata[63], in_tdata[63:32]});
  assign ux_in = dx_in[32] ? 33'(-dx_in) : dx_in;
  assign uy_in = dy_in[32] ? 33'(-dy_in) : dy_in;

  // Serial multipliers: squares on a load, centre offsets and radius products on a point.
  logic [32:0] m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;
  logic [65:0] p0, p1, p2, p3;

  always_comb begin
    if (in_tuser == tppg_pkg::KIND_NEXT) begin
      m0a = {2'b00, dir_x_mag_r};
      m0b = trav_r;
      m1a = {2'b00, dir_y_mag_r};
      m1b = trav_r;
    end else begin
      m0a = ux_in;
      m0b = ux_in;
      m1a = uy_in;
      m1b = uy_in;
    end
    m2a = {2'b00, radius_r};
    m2b = {2'b00, cos_tab[idx_r]};
    m3a = {2'b00, radius_r};
    m3b = {2'b00, sin_tab[idx_r]};
  end

  tppg_mul u_mul0 (.clk(clk), .ctl(mul_ctl), .a(m0a), .b(m0b), .prod(p0));
  tppg_mul u_mul1 (.clk(clk), .ctl(mul_ctl), .a(m1a), .b(m1b), .prod(p1));
  tppg_mul u_mul2 (.clk(clk), .ctl(mul_ctl), .a(m2a), .b(m2b), .prod(p2));
  tppg_mul u_mul3 (.clk(clk), .ctl(mul_ctl), .a(m3a), .b(m3b), .prod(p3));

  logic [30:0] qx, qy;

  tppg_div u_divx (.clk(clk), .ctl(div_ctl), .dividend({ux_r, 30'd0}), .divisor(root_r),
                   .quot(qx));
  tppg_div u_divy (.clk(clk), .ctl(div_ctl), .dividend({uy_r, 30'd0}), .divisor(root_r),
                   .quot(qy));

  // Sum of squares, the radicand of the length.
  logic [64:0] sq_sum;
  assign sq_sum = {1'b0, p0[63:0]} + {1'b0, p1[63:0]};

  // One step of the restoring square root: two radicand bits in, one root bit out.
  logic [35:0] rt_sh;
  logic [35:0] rt_trial;
  logic        rt_fits;
  assign rt_sh    = {rem_r, rad_r[65:64]};
  assign rt_trial = {1'b0, root_r, 2'b01};
  assign rt_fits  = rt_sh >= rt_trial;

  // Centre offsets and rounded radius products.
  logic [32:0] offx, offy;
  logic [61:0] rndx, rndy;
  assign offx = p0[62:30];
  assign offy = p1[62:30];
  assign rndx = p2[61:0] + 62'(tppg_pkg::Q30_HALF);
  assign rndy = p3[61:0] + 62'(tppg_pkg::Q30_HALF);

  // Final point, saturated to 32 bits.
  logic signed [36:0] sx, sy;
  logic [31:0] sat_x, sat_y;
  assign sx = {{2{cx_r[34]}}, cx_r} + (cneg_r ? 37'(-{5'd0, rx_mag_r}) : {5'd0, rx_mag_r});
  assign sy = {{2{cy_r[34]}}, cy_r} + (sneg_r ? 37'(-{5'd0, ry_mag_r}) : {5'd0, ry_mag_r});

  always_comb begin
    if (!sx[36] && (|sx[35:31])) begin
      sat_x = 32'h7FFF_FFFF;
    end else if (sx[36] && !(&sx[35:31])) begin
      sat_x = 32'h8000_0000;
    end else begin
      sat_x = sx[31:0];
    end
    if (!sy[36] && (|sy[35:31])) begin
      sat_y = 32'h7FFF_FFFF;
    end else if (sy[36] && !(&sy[35:31])) begin
      sat_y = 32'h8000_0000;
    end else begin
      sat_y = sy[31:0];
    end
  end

  // Advance of the centre at the end of a half circle; a zero step counts as one LSB.
  logic        arc_end;
  logic [33:0] trav_next;
  assign arc_end   = idx_r == IDX_W'(ARC_SEGMENTS);
  assign trav_next = {1'b0, trav_r} + {3'd0, (step_r == '0) ? 31'd1 : step_r};

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tppg_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == tppg_pkg::KIND_LOAD) begin
            state_nxt = tppg_pkg::ST_SQUARE;
          end else if (active_r) begin
            state_nxt = tppg_pkg::ST_MUL;
          end
        end
      end
      tppg_pkg::ST_SQUARE: begin
        if (cnt_r == '0) begin
          state_nxt = tppg_pkg::ST_ROOT_LD;
        end
      end
      tppg_pkg::ST_ROOT_LD: begin
        state_nxt = (sq_sum == '0) ? tppg_pkg::ST_IDLE : tppg_pkg::ST_ROOT;
      end
      tppg_pkg::ST_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = tppg_pkg::ST_DIV_LD;
        end
      end
      tppg_pkg::ST_DIV_LD: state_nxt = tppg_pkg::ST_DIV;
      tppg_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = tppg_pkg::ST_DIR;
        end
      end
      tppg_pkg::ST_DIR: state_nxt = tppg_pkg::ST_IDLE;
      tppg_pkg::ST_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = tppg_pkg::ST_COMBINE;
        end
      end
      tppg_pkg::ST_COMBINE: state_nxt = tppg_pkg::ST_OUT;
      tppg_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = tppg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tppg_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready     = state_r == tppg_pkg::ST_IDLE;
    mul_ctl.load  = accept;
    mul_ctl.step  = state_r inside {tppg_pkg::ST_SQUARE, tppg_pkg::ST_MUL};
    div_ctl.load  = state_r == tppg_pkg::ST_DIV_LD;
    div_ctl.step  = state_r == tppg_pkg::ST_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tppg_pkg::ST_IDLE;
      cnt_r       <= '0;
      radius_r    <= '0;
      step_r      <= 31'd65536;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      height_z_r  <= '0;
      dir_x_mag_r <= '0;
      dir_y_mag_r <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      seg_len_r   <= '0;
      trav_r      <= '0;
      upper_r     <= 1'b1;
      idx_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          tppg_pkg::REG_CIRCLE_RADIUS: radius_r <= cfg_data[30:0];
          tppg_pkg::REG_STEP_FORWARD:  step_r   <= cfg_data[30:0];
          default: ;
        endcase
      end

      // A new point fills the output register as the old one leaves.
      if (state_r == tppg_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end

      case (state_r)
        tppg_pkg::ST_IDLE: begin
          if (accept) begin
            cnt_r <= tppg_pkg::MUL_LAST;
            if (in_tuser == tppg_pkg::KIND_LOAD) begin
              // A load restarts the pass whatever the old pass was doing.
              origin_x_r  <= in_tdata[31:0];
              origin_y_r  <= in_tdata[63:32];
              height_z_r  <= in_tdata[95:64];
              dir_x_neg_r <= dx_in[32];
              dir_y_neg_r <= dy_in[32];
              dir_x_mag_r <= '0;
              dir_y_mag_r <= '0;
              seg_len_r   <= '0;
              trav_r      <= '0;
              upper_r     <= 1'b1;
              idx_r       <= '0;
              active_r    <= 1'b0;
            end
          end
        end
        tppg_pkg::ST_ROOT_LD: cnt_r <= tppg_pkg::ROOT_LAST;
        tppg_pkg::ST_DIV_LD: begin
          cnt_r     <= tppg_pkg::DIV_LAST;
          seg_len_r <= root_r;
        end
        tppg_pkg::ST_DIR: begin
          dir_x_mag_r <= qx;
          dir_y_mag_r <= qy;
          active_r    <= 1'b1;
        end
        tppg_pkg::ST_OUT: begin
          if (out_free) begin
            if (!arc_end) begin
              idx_r <= idx_r + 1'b1;
            end else begin
              idx_r   <= '0;
              upper_r <= !upper_r;
              trav_r  <= trav_next[32:0];
              if (trav_next >= {1'b0, seg_len_r}) begin
                active_r <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      tppg_pkg::ST_IDLE: begin
        if (accept) begin
          ux_r   <= ux_in;
          uy_r   <= uy_in;
          cneg_r <= fold_tab[idx_r] ^ !upper_r;
          sneg_r <= !upper_r;
        end
      end
      tppg_pkg::ST_ROOT_LD: begin
        rad_r  <= {1'b0, sq_sum};
        rem_r  <= '0;
        root_r <= '0;
      end
      tppg_pkg::ST_ROOT: begin
        rem_r  <= rt_fits ? 34'(rt_sh - rt_trial) : rt_sh[33:0];
        root_r <= {root_r[31:0], rt_fits};
        rad_r  <= {rad_r[63:0], 2'b00};
      end
      tppg_pkg::ST_COMBINE: begin
        cx_r     <= 35'(origin_x_r) + (dir_x_neg_r ? 35'(-{2'b00, offx}) : {2'b00, offx});
        cy_r     <= 35'(origin_y_r) + (dir_y_neg_r ? 35'(-{2'b00, offy}) : {2'b00, offy});
        rx_mag_r <= rndx[61:30];
        ry_mag_r <= rndy[61:30];
      end
      tppg_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_r <= {height_z_r, sat_y, sat_x};
          out_arc_r  <= arc_end;
          out_last_r <= arc_end && (trav_next >= {1'b0, seg_len_r});
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_arc_r;
  assign out_tlast  = out_last_r;
  assign cfg_ready  = 1'b1;

endmodule
`default_nettype wire

// ===== src/tppg_mul.sv =====
// Bit-serial 33 by 33 bit unsigned multiplier, one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none
module tppg_mul (
  input  wire logic          clk,
  input  wire tppg_pkg::ctl_t ctl,
  input  wire logic [32:0]   a,
  input  wire logic [32:0]   b,
  output logic      [65:0]   prod
);

  logic [32:0] a_r;
  logic [32:0] b_r;
  logic [65:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= {acc_r[64:0], 1'b0} + (b_r[32] ? {33'd0, a_r} : 66'd0);
      b_r   <= {b_r[31:0], 1'b0};
    end
  end

  assign prod = acc_r;

endmodule
`default_nettype wire

// ===== src/tppg_div.sv =====
// Bit-serial restoring divider: a 63-bit dividend by a 33-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tppg_div (
  input  wire logic          clk,
  input  wire tppg_pkg::ctl_t ctl,
  input  wire logic [62:0]   dividend,
  input  wire logic [32:0]   divisor,
  output logic      [30:0]   quot
);

  logic [62:0] dvd_r;
  logic [32:0] dvs_r;
  logic [32:0] rem_r;
  logic [30:0] q_r;
  logic [33:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r, dvd_r[62]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (ctl.step) begin
      rem_r <= fits ? 33'(rem_sh - {1'b0, dvs_r}) : rem_sh[32:0];
      q_r   <= {q_r[29:0], fits};
      dvd_r <= {dvd_r[61:0], 1'b0};
    end
  end

  assign quot = q_r;

endmodule
`default_nettype wire

// ===== src/tppg_checker.sv =====
// Port-level checker of the pass point generator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tppg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // The last point of a pass always closes a half circle.
  a_last_is_arc_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end of pass without end of arc");

  // A load never brings a new result word in the next cycle.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == tppg_pkg::KIND_LOAD |=> !$rose(out_tvalid))
    else $error("result word after a load");

  // A load closes the input right after it is taken, while the length is worked out.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == tppg_pkg::KIND_LOAD |=> !in_tready)
    else $error("input open right after a load");

endmodule

bind trochoidal_pass_point_generator tppg_checker u_tppg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
`default_nettype wire
